[sv/kpd_lp_pkg.sv]
// Shared types and constants for the keypad debounce / long-press block.
package kpd_lp_pkg;

  // Default geometry
  localparam int unsigned KEY_COUNT_DEF = 16;
  localparam int unsigned TIME_BITS_DEF = 32;

  // Field widths of the stream beats
  localparam int unsigned RAW_W   = 16;
  localparam int unsigned NOW_W   = 32;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned KEY_W   = 4;
  localparam int unsigned HELD_W  = 16;
  localparam int unsigned IN_DW   = 48;
  localparam int unsigned OUT_DW  = 24;

  // Configuration port
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DW    = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TIME = 1'b1;

  localparam logic [CFG_DW-1:0] DEBOUNCE_TIME_RST   = 16'd30;
  localparam logic [CFG_DW-1:0] LONG_PRESS_TIME_RST = 16'd1000;

  typedef enum logic [KIND_W-1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2,
    EV_LONG    = 2'd3
  } ev_kind_e;

endpackage

[sv/keypad_debounce_long_press_top.sv]
// Keypad debounce with press, release and long-press events, top level.
//
// One poll beat (raw key mask and millisecond time) gives exactly one result beat:
// at most one event plus the debounced key mask. Per-key edge and down times sit in
// two synchronous RAMs (dual-port for edge times, single-port for down times) and are
// swept one key per cycle. The edge-time sweep runs first; when no key flips, a second
// sweep over the down-time RAM follows. A finished result waits in the output register
// while the next poll is taken. RAM contents reset to zero through per-entry valid
// flops, so no clearing pass is needed. Configuration writes take effect at once and
// belong between polls.
module keypad_debounce_long_press_top
  import kpd_lp_pkg::*;
#(
  parameter int unsigned KEY_COUNT = KEY_COUNT_DEF,
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // poll stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DW-1:0]     s_axis_tdata,   // raw_mask[15:0], now_ms[47:16]
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_DW-1:0]    m_axis_tdata,   // key_index[3:0], was_long[4], held_mask[20:5]
  output logic [KIND_W-1:0]    m_axis_tuser,   // event_kind[1:0]
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0]    cfg_wdata_i
);

  localparam int unsigned IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int unsigned CNT_W = $clog2(KEY_COUNT + 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(KEY_COUNT);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EDGE = 4'b0010,
    ST_DOWN = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [CFG_DW-1:0]    deb_time_q, lp_time_q;
  logic [KEY_COUNT-1:0] last_raw_q, raw_q, chg_q;
  logic [TIME_BITS-1:0] now_q;
  logic [KEY_COUNT-1:0] deb_q, deb_d, long_q, long_d;
  logic [CNT_W-1:0]     rd_cnt_q, rd_cnt_d;
  logic                 ev_vld_q, ev_vld_d;
  logic [IDX_W-1:0]     ev_idx_q, ev_idx_d;
  logic                 hit_q, hit_d;
  logic [IDX_W-1:0]     hit_idx_q, hit_idx_d;
  ev_kind_e             kind_q, kind_d;
  logic                 wl_q, wl_d;

  // timestamp RAMs
  logic [TIME_BITS-1:0] edge_mem [KEY_COUNT];
  logic [TIME_BITS-1:0] down_mem [KEY_COUNT];
  logic [KEY_COUNT-1:0] edge_vld_q, down_vld_q;
  logic [TIME_BITS-1:0] edge_rd_q, down_rd_q;
  logic                 edge_rv_q, down_rv_q;

  logic                 m_valid_q;
  ev_kind_e             m_kind_q;
  logic [KEY_W-1:0]     m_key_q;
  logic                 m_wl_q;
  logic [HELD_W-1:0]    m_held_q;

  logic                 accept, out_load;
  logic                 rd_go, pass_end;
  logic [IDX_W-1:0]     rd_idx;
  logic                 edge_re, down_re, edge_we, down_we;
  logic [TIME_BITS-1:0] edge_eff, down_eff, edge_age, down_age;
  logic                 flip_ok, long_ok;
  logic [KEY_COUNT-1:0] raw_in;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign raw_in        = KEY_COUNT'(s_axis_tdata[15:0]);

  assign rd_go    = (rd_cnt_q != CNT_END);
  assign pass_end = (rd_cnt_q == CNT_END) && !ev_vld_q;
  assign rd_idx   = rd_cnt_q[IDX_W-1:0];
  assign edge_re  = (state_q == ST_EDGE) && rd_go;
  assign down_re  = (state_q == ST_DOWN) && rd_go;

  // a key whose raw level changed in this poll takes the current time as edge
  assign edge_eff = chg_q[ev_idx_q] ? now_q : (edge_rv_q ? edge_rd_q : '0);
  assign down_eff = down_rv_q ? down_rd_q : '0;
  assign edge_age = now_q - edge_eff;
  assign down_age = now_q - down_eff;

  assign flip_ok = (raw_q[ev_idx_q] != deb_q[ev_idx_q]) &&
                   (edge_age >= TIME_BITS'(deb_time_q));
  assign long_ok = deb_q[ev_idx_q] && !long_q[ev_idx_q] &&
                   (down_age >= TIME_BITS'(lp_time_q));

  assign edge_we = (state_q == ST_EDGE) && ev_vld_q && chg_q[ev_idx_q];
  assign down_we = (state_q == ST_EDGE) && pass_end && hit_q && raw_q[hit_idx_q];

  always_comb begin
    state_d   = state_q;
    deb_d     = deb_q;
    long_d    = long_q;
    rd_cnt_d  = rd_cnt_q;
    ev_vld_d  = 1'b0;
    ev_idx_d  = ev_idx_q;
    hit_d     = hit_q;
    hit_idx_d = hit_idx_q;
    kind_d    = kind_q;
    wl_d      = wl_q;
    out_load  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d  = ST_EDGE;
          rd_cnt_d = '0;
          hit_d    = 1'b0;
          kind_d   = EV_NONE;
          wl_d     = 1'b0;
        end
      end
      ST_EDGE, ST_DOWN: begin
        if (rd_go) begin
          rd_cnt_d = rd_cnt_q + 1'b1;
          ev_vld_d = 1'b1;
          ev_idx_d = rd_idx;
        end
        // keep the lowest candidate only
        if (ev_vld_q && !hit_q &&
            (((state_q == ST_EDGE) && flip_ok) || ((state_q == ST_DOWN) && long_ok))) begin
          hit_d     = 1'b1;
          hit_idx_d = ev_idx_q;
        end
        if (pass_end) begin
          if (state_q == ST_EDGE) begin
            if (hit_q) begin
              state_d           = ST_FIN;
              deb_d[hit_idx_q]  = raw_q[hit_idx_q];
              long_d[hit_idx_q] = 1'b0;
              if (raw_q[hit_idx_q]) begin
                kind_d = EV_PRESS;
              end else begin
                kind_d = EV_RELEASE;
                wl_d   = long_q[hit_idx_q];
              end
            end else begin
              state_d  = ST_DOWN;
              rd_cnt_d = '0;
            end
          end else begin
            state_d = ST_FIN;
            if (hit_q) begin
              long_d[hit_idx_q] = 1'b1;
              kind_d            = EV_LONG;
            end
          end
        end
      end
      ST_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      deb_time_q <= DEBOUNCE_TIME_RST;
      lp_time_q  <= LONG_PRESS_TIME_RST;
      last_raw_q <= '0;
      deb_q      <= '0;
      long_q     <= '0;
      rd_cnt_q   <= '0;
      ev_vld_q   <= 1'b0;
      hit_q      <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      deb_q    <= deb_d;
      long_q   <= long_d;
      rd_cnt_q <= rd_cnt_d;
      ev_vld_q <= ev_vld_d;
      hit_q    <= hit_d;
      if (accept) begin
        last_raw_q <= raw_in;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DEBOUNCE_TIME:   deb_time_q <= cfg_wdata_i;
          REG_LONG_PRESS_TIME: lp_time_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ev_idx_q  <= ev_idx_d;
    hit_idx_q <= hit_idx_d;
    kind_q    <= kind_d;
    wl_q      <= wl_d;
    if (accept) begin
      raw_q <= raw_in;
      chg_q <= raw_in ^ last_raw_q;
      now_q <= TIME_BITS'(s_axis_tdata[47:16]);
    end
    if (out_load) begin
      m_kind_q <= kind_q;
      m_key_q  <= (kind_q == EV_NONE) ? '0 : KEY_W'(hit_idx_q);
      m_wl_q   <= wl_q;
      m_held_q <= HELD_W'(deb_q);
    end
  end

  // RAM valid bits: an entry never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_vld_q <= '0;
      down_vld_q <= '0;
      edge_rv_q  <= 1'b0;
      down_rv_q  <= 1'b0;
    end else begin
      if (edge_we) edge_vld_q[ev_idx_q] <= 1'b1;
      if (down_we) down_vld_q[hit_idx_q] <= 1'b1;
      if (edge_re) edge_rv_q <= edge_vld_q[rd_idx];
      if (down_re) down_rv_q <= down_vld_q[rd_idx];
    end
  end

  // edge-time RAM: write lags the read by one key, never the same entry
  always_ff @(posedge clk_i) begin
    if (edge_we) edge_mem[ev_idx_q] <= now_q;
    if (edge_re) edge_rd_q <= edge_mem[rd_idx];
  end

  // down-time RAM: written after the edge sweep, read only in the down sweep
  always_ff @(posedge clk_i) begin
    if (down_we) down_mem[hit_idx_q] <= now_q;
    if (down_re) down_rd_q <= down_mem[rd_idx];
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tdata  = {3'b000, m_held_q, m_wl_q, m_key_q};

`ifndef ASSERT_OFF
  a_flip_one_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EDGE && pass_end && hit_q) |=>
      ($countones(deb_q ^ $past(deb_q)) == 1))
    else $error("debounced mask changed in more than one key");

  a_long_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((long_q & ~deb_q) == '0))
    else $error("long flag set on a key that is not held");

  a_eval_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_vld_q |-> (state_q == ST_EDGE || state_q == ST_DOWN))
    else $error("RAM read data evaluated outside a sweep");
`endif

endmodule

[dv/kpd_lp_event_monitor.sv]
// Watches the poll, result and register ports; predicts each key event and compares it.
`timescale 1ns / 1ps

module kpd_lp_event_monitor
  import kpd_lp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 poll_valid_i,
  input  logic                 poll_ready_i,
  input  logic [IN_DW-1:0]     poll_data_i,
  input  logic                 res_valid_i,
  input  logic                 res_ready_i,
  input  logic [OUT_DW-1:0]    res_data_i,
  input  logic [KIND_W-1:0]    res_kind_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0]    cfg_wdata_i,
  output int                   mismatches_o,
  output int                   pending_o,
  output int                   checked_o,
  output int                   presses_o,
  output int                   releases_o,
  output int                   longs_o
);

  typedef struct packed {
    ev_kind_e          kind;
    logic [KEY_W-1:0]  key;
    logic              was_long;
    logic [HELD_W-1:0] held;
  } key_event_t;

  // predictor state, one bit or one timestamp per key
  logic [RAW_W-1:0]  raw_seen;
  logic [RAW_W-1:0]  held_keys;
  logic [RAW_W-1:0]  long_done;
  logic [NOW_W-1:0]  edge_ms [KEY_COUNT_DEF];
  logic [NOW_W-1:0]  down_ms [KEY_COUNT_DEF];
  logic [CFG_DW-1:0] debounce_ms;
  logic [CFG_DW-1:0] long_press_ms;

  key_event_t expected_events [$];
  key_event_t want_ev;
  key_event_t got_ev;
  int         mismatches;
  int         checked;
  int         presses;
  int         releases;
  int         longs;

  // one poll: restart edge times, flip the lowest settled key, else raise a long press
  function automatic key_event_t poll_keypad(logic [RAW_W-1:0] raw, logic [NOW_W-1:0] now);
    key_event_t ev;
    logic [RAW_W-1:0] changed;
    bit done;
    ev.kind     = EV_NONE;
    ev.key      = '0;
    ev.was_long = 1'b0;
    ev.held     = '0;
    done        = 1'b0;
    changed     = raw ^ raw_seen;
    for (int k = 0; k < KEY_COUNT_DEF; k++) begin
      if (changed[k]) edge_ms[k] = now;
    end
    raw_seen = raw;
    for (int k = 0; k < KEY_COUNT_DEF && !done; k++) begin
      if (raw[k] != held_keys[k] && NOW_W'(now - edge_ms[k]) >= NOW_W'(debounce_ms)) begin
        if (raw[k]) begin
          held_keys[k] = 1'b1;
          down_ms[k]   = now;
          long_done[k] = 1'b0;
          ev.kind      = EV_PRESS;
        end else begin
          held_keys[k] = 1'b0;
          ev.was_long  = long_done[k];
          long_done[k] = 1'b0;
          ev.kind      = EV_RELEASE;
        end
        ev.key = KEY_W'(k);
        done   = 1'b1;
      end
    end
    for (int k = 0; k < KEY_COUNT_DEF && !done; k++) begin
      if (held_keys[k] && !long_done[k] &&
          NOW_W'(now - down_ms[k]) >= NOW_W'(long_press_ms)) begin
        long_done[k] = 1'b1;
        ev.kind      = EV_LONG;
        ev.key       = KEY_W'(k);
        done         = 1'b1;
      end
    end
    ev.held = held_keys;
    return ev;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_seen      = '0;
      held_keys     = '0;
      long_done     = '0;
      debounce_ms   = DEBOUNCE_TIME_RST;
      long_press_ms = LONG_PRESS_TIME_RST;
      for (int k = 0; k < KEY_COUNT_DEF; k++) begin
        edge_ms[k] = '0;
        down_ms[k] = '0;
      end
      expected_events.delete();
      mismatches = 0;
      checked    = 0;
      presses    = 0;
      releases   = 0;
      longs      = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DEBOUNCE_TIME:   debounce_ms   = cfg_wdata_i;
          REG_LONG_PRESS_TIME: long_press_ms = cfg_wdata_i;
          default: ;
        endcase
      end
      if (res_valid_i && res_ready_i) begin
        got_ev.kind     = ev_kind_e'(res_kind_i);
        got_ev.key      = res_data_i[KEY_W-1:0];
        got_ev.was_long = res_data_i[KEY_W];
        got_ev.held     = res_data_i[KEY_W+1 +: HELD_W];
        if (expected_events.size() == 0) begin
          $error("result beat with no poll outstanding: kind %0d key %0d",
                 got_ev.kind, got_ev.key);
          mismatches++;
        end else begin
          want_ev = expected_events.pop_front();
          checked++;
          if (got_ev.kind != want_ev.kind) begin
            $error("event_kind: expected %0d, got %0d", want_ev.kind, got_ev.kind);
            mismatches++;
          end
          if (got_ev.key != want_ev.key) begin
            $error("key_index: expected %0d, got %0d", want_ev.key, got_ev.key);
            mismatches++;
          end
          if (got_ev.was_long != want_ev.was_long) begin
            $error("was_long: expected %0d, got %0d", want_ev.was_long, got_ev.was_long);
            mismatches++;
          end
          if (got_ev.held != want_ev.held) begin
            $error("held_mask: expected %h, got %h", want_ev.held, got_ev.held);
            mismatches++;
          end
          case (want_ev.kind)
            EV_PRESS:   presses++;
            EV_RELEASE: releases++;
            EV_LONG:    longs++;
            default: ;
          endcase
        end
      end
      if (poll_valid_i && poll_ready_i)
        expected_events.push_back(poll_keypad(poll_data_i[RAW_W-1:0],
                                              poll_data_i[RAW_W +: NOW_W]));
    end
    // published a delta late so the stimulus side never sees a half-updated count
    mismatches_o <= mismatches;
    pending_o    <= expected_events.size();
    checked_o    <= checked;
    presses_o    <= presses;
    releases_o   <= releases;
    longs_o      <= longs;
  end

endmodule

[dv/testbench.sv]
// Top of the keypad debounce testbench: clock, reset, poll stimulus, result stalls, verdict.
`timescale 1ns / 1ps

module testbench;
  import kpd_lp_pkg::*;

  localparam int PHASES     = 6;
  localparam int PHASE_LEN  = 80;
  localparam int CALM_ITEMS = 60;
  localparam int LONG_HOLD  = 400;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_DW-1:0]     s_axis_tdata  = '0;   // raw_mask[15:0], now_ms[47:16]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_DW-1:0]    m_axis_tdata;         // key_index[3:0], was_long[4], held_mask[20:5]
  logic [KIND_W-1:0]    m_axis_tuser;         // event_kind[1:0]
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = REG_DEBOUNCE_TIME;
  logic [CFG_DW-1:0]    cfg_wdata_i   = '0;

  int mismatches, pending, checked, presses, releases, longs;

  // stimulus-side state
  bit               calm           = 1'b0;
  bit               want_long_hold = 1'b0;
  bit               long_hold_done = 1'b0;
  int               hold_cnt       = 0;
  logic [RAW_W-1:0] key_target     = '0;
  logic [NOW_W-1:0] clock_ms       = '0;
  int               polls_sent     = 0;

  always #10 clk_i = ~clk_i;

  keypad_debounce_long_press_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  kpd_lp_event_monitor monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .poll_valid_i (s_axis_tvalid),
    .poll_ready_i (s_axis_tready),
    .poll_data_i  (s_axis_tdata),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .res_kind_i   (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked),
    .presses_o    (presses),
    .releases_o   (releases),
    .longs_o      (longs)
  );

  // result side: short random stalls, one long hold-off on request, none once calm
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= hold_cnt - 1;
    end else if (want_long_hold && !long_hold_done) begin
      m_axis_tready  <= 1'b0;
      hold_cnt       <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= $urandom_range(0, 13);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_poll(input logic [RAW_W-1:0] raw, input logic [NOW_W-1:0] now);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {now, raw};
    do @(posedge clk_i); while (!s_axis_tready);
    key_target = raw;
    clock_ms   = now;
    polls_sent++;
  endtask

  // stop offering and wait until every poll has had its result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic program_timing(input logic [CFG_DW-1:0] deb, input logic [CFG_DW-1:0] lp);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_DEBOUNCE_TIME;
    cfg_wdata_i <= deb;
    @(posedge clk_i);
    cfg_idx_i   <= REG_LONG_PRESS_TIME;
    cfg_wdata_i <= lp;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // key held steady for a while with occasional bounce and noise; time steps scaled
  // to the debounce and long-press settings so that all event kinds turn up
  task automatic random_poll(input int unsigned deb, input int unsigned lp);
    int unsigned pick;
    int unsigned step;
    int          bit_no;
    logic [RAW_W-1:0] target;
    logic [RAW_W-1:0] raw;
    pick = $urandom_range(0, 99);
    if (pick < 70)      step = $urandom_range(0, deb / 2 + 2);
    else if (pick < 90) step = $urandom_range(deb, deb + lp / 4 + 4);
    else if (pick < 98) step = $urandom_range(lp / 2, lp + deb + 8);
    else                step = $urandom;
    target = key_target;
    pick   = $urandom_range(0, 99);
    bit_no = $urandom_range(0, RAW_W - 1);
    if (pick < 12)      target[bit_no] = ~target[bit_no];
    else if (pick < 15) target = RAW_W'($urandom);
    raw    = target;
    pick   = $urandom_range(0, 99);
    bit_no = $urandom_range(0, RAW_W - 1);
    if (pick < 15)      raw[bit_no] = ~raw[bit_no];
    else if (pick < 19) raw = raw ^ RAW_W'($urandom);
    send_poll(raw, clock_ms + step);
    key_target = target;
  endtask

  initial begin
    logic [RAW_W-1:0] dir_raw [21];
    logic [NOW_W-1:0] dir_now [21];
    int unsigned      deb_set [PHASES];
    int unsigned      lp_set  [PHASES];

    // at reset timing: presses, long presses, releases with and without the long
    // flag, a bounce that settles back, time wrap, and the field extremes
    dir_raw = '{16'h0000, 16'h8001, 16'h8001, 16'h8001, 16'h8001, 16'h8001, 16'h8001,
                16'h8001, 16'h0001, 16'h0001, 16'h0003, 16'h0001, 16'h0003, 16'h0003,
                16'h0001, 16'h0001, 16'h0001, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF};
    dir_now = '{32'd0, 32'd10, 32'd39, 32'd40, 32'd41, 32'd1040, 32'd1041,
                32'd1042, 32'd1050, 32'd1080, 32'd1081, 32'd1090, 32'd1100, 32'd1130,
                32'd1140, 32'd1170, 32'hFFFF_FFF0, 32'hFFFF_FFF5, 32'h0000_0013,
                32'hFFFF_FFFF, 32'd29};
    deb_set = '{0, 65535, 5, 0, 40, 30};
    lp_set  = '{0, 65535, 60, 700, 0, 1000};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_raw[i]) send_poll(dir_raw[i], dir_now[i]);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      program_timing(CFG_DW'(deb_set[p]), CFG_DW'(lp_set[p]));
      for (int i = 0; i < PHASE_LEN; i++) begin
        if (p == 1 && i == 20) want_long_hold = 1'b1;
        if (p == PHASES - 1 && i == PHASE_LEN - CALM_ITEMS) calm = 1'b1;
        random_poll(deb_set[p], lp_set[p]);
      end
    end

    drain();
    repeat (50) @(posedge clk_i);
    $display("%0d polls over %0d timing settings, %0d results checked", polls_sent,
             PHASES + 1, checked);
    $display("events seen: %0d presses, %0d releases, %0d long presses", presses,
             releases, longs);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
